FILE: hdl/pnpe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pnpe_pkg
// Shared widths, command codes and register indexes of the Perlin point
// evaluation unit.
// ----------------------------------------------------------------------------
package pnpe_pkg;

   localparam int FRAC_BITS_DEF = 16;
   localparam int TBL_DEPTH     = 256;
   localparam int TBL_AW        = 8;
   localparam int TBL_DW        = 8;
   localparam int POS_W         = 40;
   localparam int OFF_W         = 24;
   localparam int ACC_W         = 48;
   localparam int AMP_W         = 4;
   localparam int CMD_W         = 2;
   localparam int CSR_IDX_W     = 2;

   localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_EVAL2D = 2'd1;
   localparam logic [CMD_W-1:0] CMD_EVAL3D = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_X  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_Y  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_Z  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_AMP_SHIFT = 2'd3;

   localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

endpackage

FILE: hdl/pnpe_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pnpe_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module pnpe_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [0:DEPTH-1];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

FILE: hdl/perlin_noise_point_eval_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// perlin_noise_point_eval_unit
// Improved Perlin gradient noise at one point, scaled by 2^amp_shift and added
// to a running sum with saturation. Keeps the four y-cell blends in 3D.
// ----------------------------------------------------------------------------
//  channel  | ports                              | direction
//  req      | req_valid/req_stall + fields       | in  (load or evaluate)
//  rsp      | rsp_valid/rsp_stall + rsp_acc_out  | out (one per evaluate)
//  csr      | csr_write, csr_index, csr_data     | in  (write only)
//
// A table load is written at its request transfer. An evaluate stalls further
// requests until its result is registered, and its steps are set by the one
// shared multiplier (12 fade products, 7 blend products) and the single read
// port of the permutation table (14 reads).
// Reset is synchronous; the table content is undefined until loaded.
// A stalled result holds the unit in its last step; a new request is taken
// while an earlier result still waits.
// ----------------------------------------------------------------------------
module perlin_noise_point_eval_unit #(
   parameter int FRAC_BITS = pnpe_pkg::FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write,
   input  logic [pnpe_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [pnpe_pkg::OFF_W-1:0]          csr_data,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [pnpe_pkg::CMD_W-1:0]          req_cmd,
   input  logic [pnpe_pkg::TBL_AW-1:0]         req_table_index,
   input  logic [pnpe_pkg::TBL_DW-1:0]         req_table_value,
   input  logic signed [pnpe_pkg::POS_W-1:0]   req_pos_x,
   input  logic signed [pnpe_pkg::POS_W-1:0]   req_pos_y,
   input  logic signed [pnpe_pkg::POS_W-1:0]   req_pos_z,
   input  logic                                req_column_start,
   input  logic signed [pnpe_pkg::ACC_W-1:0]   req_acc_in,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [pnpe_pkg::ACC_W-1:0]   rsp_acc_out
);

   localparam int MW   = FRAC_BITS + 6;
   localparam int PW   = 2 * MW;
   localparam int SW   = pnpe_pkg::POS_W + 1;
   localparam int LYW  = SW - FRAC_BITS;
   localparam int AW   = pnpe_pkg::TBL_AW;
   localparam int ACCW = pnpe_pkg::ACC_W;
   localparam int MAXSHIFT = (1 << pnpe_pkg::AMP_W) - 1;
   localparam int SUMW = ((MW + MAXSHIFT > ACCW) ? MW + MAXSHIFT : ACCW) + 1;

   localparam logic signed [MW-1:0] ONE_FX     = MW'(64'd1 << FRAC_BITS);
   localparam logic signed [MW-1:0] TEN_FX     = MW'(64'd10 << FRAC_BITS);
   localparam logic signed [MW-1:0] FIFTEEN_FX = MW'(64'd15 << FRAC_BITS);

   localparam logic [4:0] STEP_LERP_X0 = 5'd15;
   localparam logic [4:0] STEP_LERP_X1 = 5'd16;
   localparam logic [4:0] STEP_LERP_X2 = 5'd17;
   localparam logic [4:0] STEP_LERP_X3 = 5'd18;
   localparam logic [4:0] STEP_BLEND3  = 5'd19;
   localparam logic [4:0] STEP_LERP_Y0 = 5'd20;
   localparam logic [4:0] STEP_LERP_Y1 = 5'd21;
   localparam logic [4:0] STEP_Y1      = 5'd22;
   localparam logic [4:0] STEP_LERP_Z  = 5'd23;
   localparam logic [4:0] STEP_SUM     = 5'd24;
   localparam logic [4:0] STEP_OUT     = 5'd25;

   typedef enum logic {S_IDLE, S_RUN} state_type;

   state_type state_ff;
   logic [4:0] step_ff;

   logic [pnpe_pkg::OFF_W-1:0] off_x_ff, off_y_ff, off_z_ff;
   logic [pnpe_pkg::AMP_W-1:0] amp_ff;

   logic [FRAC_BITS-1:0]    fr_ff [0:2];
   logic [AW-1:0]           px_ff, py_ff, pz_ff, ha_ff, hb_ff;
   logic [AW-1:0]           hh_ff [0:3];
   logic signed [MW-1:0]    g_ff [0:7];
   logic signed [MW-1:0]    wb_ff [0:3];
   logic signed [MW-1:0]    cache_ff [0:3];
   logic signed [MW-1:0]    tf_ff [0:2];
   logic signed [MW-1:0]    c_ff, prod_ff, y0_ff, y1_ff, n_ff;
   logic signed [ACCW-1:0]  acc_ff;
   logic [LYW-1:0]          last_ly_ff;
   logic                    is3d_ff, hit_ff;
   logic                    rsp_valid_ff;
   logic signed [ACCW-1:0]  rsp_acc_out_ff;

   logic                    req_accept;
   logic                    is_eval, is_3d, hit_now;
   logic signed [SW-1:0]    sx, sy, sz;
   logic [LYW-1:0]          ly;
   logic [AW-1:0]           rd_addr, rd_data;
   logic                    wr_en;
   logic [1:0]              axis;
   logic signed [MW-1:0]    t_ext, opa, opb, prod_next;
   logic signed [PW-1:0]    product;
   logic signed [MW-1:0]    bl [0:3];
   logic [2:0]              gi;
   logic signed [MW-1:0]    fx_s, fy_s, fz_s, gx_s, gy_s, gz_s, gcap;
   logic signed [SUMW-1:0]  scaled, sum;
   logic [SUMW-ACCW:0]      sum_hi;
   logic signed [ACCW-1:0]  total;
   logic                    out_free;
   logic                    rsp_load;

   function automatic logic signed [MW-1:0] grad_val(
      input logic [3:0]           h,
      input logic                 flat,
      input logic signed [MW-1:0] x,
      input logic signed [MW-1:0] y,
      input logic signed [MW-1:0] z
   );
      logic signed [MW-1:0] u, v;
      if (flat) begin
         u = h[3] ? '0 : x;
      end else begin
         u = h[3] ? y : x;
      end
      if (h < 4'd4) begin
         v = flat ? '0 : y;
      end else if (h == 4'd12 || h == 4'd14) begin
         v = x;
      end else begin
         v = z;
      end
      return (h[0] ? -u : u) + (h[1] ? -v : v);
   endfunction

   assign req_stall   = (state_ff != S_IDLE);
   assign req_accept  = req_valid && !req_stall;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_acc_out = rsp_acc_out_ff;

   // point setup at the request transfer
   assign sx      = SW'(req_pos_x) + SW'(off_x_ff);
   assign sy      = SW'(req_pos_y) + SW'(off_y_ff);
   assign sz      = SW'(req_pos_z) + SW'(off_z_ff);
   assign ly      = sy[SW-1:FRAC_BITS];
   assign is_3d   = (req_cmd == pnpe_pkg::CMD_EVAL3D);
   assign is_eval = is_3d || (req_cmd == pnpe_pkg::CMD_EVAL2D);
   assign hit_now = is_3d && !req_column_start && (ly == last_ly_ff);
   assign wr_en   = req_accept && (req_cmd == pnpe_pkg::CMD_LOAD);

   pnpe_ram #(
      .WIDTH (pnpe_pkg::TBL_DW),
      .DEPTH (pnpe_pkg::TBL_DEPTH)
   ) u_perm (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (req_table_index),
      .wr_data (req_table_value),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // table read schedule: two cell levels, then four hashes, then eight gradients
   always_comb begin
      case (step_ff)
         5'd0:    rd_addr = px_ff;
         5'd1:    rd_addr = AW'(px_ff + 1'b1);
         5'd2:    rd_addr = AW'(ha_ff + py_ff);
         5'd3:    rd_addr = AW'(hb_ff + py_ff);
         5'd4:    rd_addr = AW'(ha_ff + py_ff + 1'b1);
         5'd5:    rd_addr = AW'(hb_ff + py_ff + 1'b1);
         5'd6:    rd_addr = hh_ff[0];
         5'd7:    rd_addr = hh_ff[1];
         5'd8:    rd_addr = hh_ff[2];
         5'd9:    rd_addr = hh_ff[3];
         5'd10:   rd_addr = AW'(hh_ff[0] + 1'b1);
         5'd11:   rd_addr = AW'(hh_ff[1] + 1'b1);
         5'd12:   rd_addr = AW'(hh_ff[2] + 1'b1);
         5'd13:   rd_addr = AW'(hh_ff[3] + 1'b1);
         default: rd_addr = '0;
      endcase
   end

   // gradient of the corner whose hash arrives in this step
   assign gi   = 3'(step_ff - 5'd7);
   assign fx_s = MW'(fr_ff[0]);
   assign fy_s = MW'(fr_ff[1]);
   assign fz_s = MW'(fr_ff[2]);
   assign gx_s = fx_s - ONE_FX;
   assign gy_s = fy_s - ONE_FX;
   assign gz_s = fz_s - ONE_FX;
   assign gcap = grad_val(rd_data[3:0], !is3d_ff && (gi == 3'd0),
                          gi[0] ? gx_s : fx_s,
                          gi[1] ? gy_s : fy_s,
                          gi[2] ? gz_s : fz_s);

   always_comb begin
      for (int j = 0; j < 4; j++) begin
         bl[j] = hit_ff ? cache_ff[j] : wb_ff[j];
      end
   end

   // shared multiplier: three fades, then x, y and z blends
   assign axis  = step_ff[3:2];
   assign t_ext = MW'(fr_ff[axis]);

   always_comb begin
      case (step_ff) inside
         [5'd0:5'd11]: begin
            case (step_ff[1:0])
               2'd0: begin
                  opa = t_ext;
                  opb = (t_ext <<< 2) + (t_ext <<< 1) - FIFTEEN_FX;
               end
               2'd1: begin
                  opa = t_ext;
                  opb = t_ext;
               end
               2'd2: begin
                  opa = prod_ff;
                  opb = t_ext;
               end
               default: begin
                  opa = prod_ff;
                  opb = c_ff;
               end
            endcase
         end
         STEP_LERP_X0: begin
            opa = tf_ff[0];
            opb = g_ff[1] - g_ff[0];
         end
         STEP_LERP_X1: begin
            opa = tf_ff[0];
            opb = g_ff[3] - g_ff[2];
         end
         STEP_LERP_X2: begin
            opa = tf_ff[0];
            opb = g_ff[5] - g_ff[4];
         end
         STEP_LERP_X3: begin
            opa = tf_ff[0];
            opb = g_ff[7] - g_ff[6];
         end
         STEP_LERP_Y0: begin
            opa = tf_ff[1];
            opb = bl[1] - bl[0];
         end
         STEP_LERP_Y1: begin
            opa = tf_ff[1];
            opb = bl[3] - bl[2];
         end
         STEP_LERP_Z: begin
            opa = tf_ff[2];
            opb = y1_ff - y0_ff;
         end
         default: begin
            opa = '0;
            opb = '0;
         end
      endcase
   end

   assign product   = opa * opb;
   assign prod_next = MW'(product >>> FRAC_BITS);

   // scale and saturate
   assign scaled   = SUMW'(n_ff) <<< amp_ff;
   assign sum      = scaled + SUMW'(acc_ff);
   assign sum_hi   = sum[SUMW-1:ACCW-1];
   assign total    = ((&sum_hi) || !(|sum_hi)) ? sum[ACCW-1:0] :
                     (sum[SUMW-1] ? pnpe_pkg::ACC_MIN : pnpe_pkg::ACC_MAX);
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_load = (state_ff == S_RUN) && (step_ff == STEP_OUT) && out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         last_ly_ff   <= '1;
         off_x_ff     <= '0;
         off_y_ff     <= '0;
         off_z_ff     <= '0;
         amp_ff       <= '0;
         for (int j = 0; j < 4; j++) begin
            cache_ff[j] <= '0;
         end
      end else begin
         if (csr_write) begin
            case (csr_index)
               pnpe_pkg::CSR_OFFSET_X:  off_x_ff <= csr_data;
               pnpe_pkg::CSR_OFFSET_Y:  off_y_ff <= csr_data;
               pnpe_pkg::CSR_OFFSET_Z:  off_z_ff <= csr_data;
               pnpe_pkg::CSR_AMP_SHIFT: amp_ff   <= csr_data[pnpe_pkg::AMP_W-1:0];
               default: ;
            endcase
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_accept && is_eval) begin
                  state_ff <= S_RUN;
                  step_ff  <= '0;
                  if (is_3d && !hit_now) begin
                     last_ly_ff <= ly;
                  end
               end
            end
            S_RUN: begin
               if (step_ff == STEP_LERP_Y0 && is3d_ff && !hit_ff) begin
                  for (int j = 0; j < 4; j++) begin
                     cache_ff[j] <= wb_ff[j];
                  end
               end
               if (step_ff == STEP_OUT) begin
                  if (out_free) begin
                     rsp_acc_out_ff <= total;
                     state_ff       <= S_IDLE;
                  end
               end else begin
                  step_ff <= step_ff + 5'd1;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (req_accept && is_eval) begin
         is3d_ff  <= is_3d;
         hit_ff   <= hit_now;
         acc_ff   <= req_acc_in;
         px_ff    <= sx[FRAC_BITS+AW-1:FRAC_BITS];
         pz_ff    <= sz[FRAC_BITS+AW-1:FRAC_BITS];
         py_ff    <= is_3d ? sy[FRAC_BITS+AW-1:FRAC_BITS] : '0;
         fr_ff[0] <= sx[FRAC_BITS-1:0];
         fr_ff[1] <= is_3d ? sy[FRAC_BITS-1:0] : '0;
         fr_ff[2] <= sz[FRAC_BITS-1:0];
      end
      prod_ff <= prod_next;
      case (step_ff) inside
         5'd1:          ha_ff <= rd_data;
         5'd2:          hb_ff <= rd_data;
         5'd3:          hh_ff[0] <= AW'(rd_data + pz_ff);
         5'd4:          hh_ff[1] <= AW'(rd_data + pz_ff);
         5'd5:          hh_ff[2] <= AW'(rd_data + pz_ff);
         5'd6:          hh_ff[3] <= AW'(rd_data + pz_ff);
         [5'd7:5'd14]:  g_ff[gi] <= gcap;
         default: ;
      endcase
      // fade: c = b + 10 once b is out; the result passes through the product register into tf
      case (step_ff)
         5'd1, 5'd5, 5'd9: c_ff <= prod_ff + TEN_FX;
         default: ;
      endcase
      case (step_ff)
         5'd4:         tf_ff[0] <= prod_ff;
         5'd8:         tf_ff[1] <= prod_ff;
         5'd12:        tf_ff[2] <= prod_ff;
         STEP_LERP_X1: wb_ff[0] <= g_ff[0] + prod_ff;
         STEP_LERP_X2: wb_ff[1] <= g_ff[2] + prod_ff;
         STEP_LERP_X3: wb_ff[2] <= g_ff[4] + prod_ff;
         STEP_BLEND3:  wb_ff[3] <= g_ff[6] + prod_ff;
         STEP_LERP_Y1: y0_ff    <= bl[0] + prod_ff;
         STEP_Y1:      y1_ff    <= bl[2] + prod_ff;
         STEP_SUM:     n_ff     <= y0_ff + prod_ff;
         default: ;
      endcase
   end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the Perlin point evaluation unit. A noise model
// inside a small scoreboard predicts every accumulated sum from the accepted
// requests; results are checked in order under random idling on both sides.
// ----------------------------------------------------------------------------
module tb;

   typedef struct {
      logic [pnpe_pkg::CMD_W-1:0]         cmd;
      logic [pnpe_pkg::TBL_AW-1:0]        tidx;
      logic [pnpe_pkg::TBL_DW-1:0]        tval;
      logic signed [pnpe_pkg::POS_W-1:0]  px;
      logic signed [pnpe_pkg::POS_W-1:0]  py;
      logic signed [pnpe_pkg::POS_W-1:0]  pz;
      logic                               col;
      logic signed [pnpe_pkg::ACC_W-1:0]  acc;
   } noise_req_type;

   localparam logic [pnpe_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam int  FB       = pnpe_pkg::FRAC_BITS_DEF;
   localparam longint ONE   = longint'(1) << FB;
   localparam int  DRAIN    = 60;
   localparam int  HOLD_OFF = 400;
   localparam int  LIMIT    = 2000000;

   localparam logic [pnpe_pkg::OFF_W-1:0] OX [6] =
      '{24'h0, 24'hFFFFFF, 24'h123456, 24'h0, 24'h8000, 24'hFFFFFF};
   localparam logic [pnpe_pkg::OFF_W-1:0] OY [6] =
      '{24'h0, 24'hFFFFFF, 24'h0ABCDE, 24'hFFFFFF, 24'h7FFF, 24'h0};
   localparam logic [pnpe_pkg::OFF_W-1:0] OZ [6] =
      '{24'h0, 24'hFFFFFF, 24'hFEDCBA, 24'h1, 24'h0, 24'h800000};
   localparam logic [pnpe_pkg::OFF_W-1:0] AM [6] =
      '{24'd0, 24'd15, 24'd3, 24'd8, 24'd1, 24'd15};

   class scoreboard_type;
      logic [7:0]  perm_tbl [256];
      longint      cell_y;
      longint      blend [4];
      longint      off_x, off_y, off_z;
      int          shift;
      logic signed [pnpe_pkg::ACC_W-1:0] pending [$];
      int          errors;

      function new();
         cell_y = -1;
         foreach (blend[i]) blend[i] = 0;
         off_x = 0; off_y = 0; off_z = 0; shift = 0; errors = 0;
      endfunction

      function void set_reg(logic [pnpe_pkg::CSR_IDX_W-1:0] idx,
                            logic [pnpe_pkg::OFF_W-1:0] val);
         case (idx)
            pnpe_pkg::CSR_OFFSET_X:  off_x = val;
            pnpe_pkg::CSR_OFFSET_Y:  off_y = val;
            pnpe_pkg::CSR_OFFSET_Z:  off_z = val;
            pnpe_pkg::CSR_AMP_SHIFT: shift = val[pnpe_pkg::AMP_W-1:0];
            default: ;
         endcase
      endfunction

      function longint pv(longint i);
         return perm_tbl[i & 255];
      endfunction

      function longint fade(longint t);
         longint b, c, d, e;
         b = (t * (6 * t - 15 * ONE)) >>> FB;
         c = b + 10 * ONE;
         d = (t * t) >>> FB;
         e = (d * t) >>> FB;
         return (e * c) >>> FB;
      endfunction

      function longint lerp(longint t, longint a, longint b);
         return a + ((t * (b - a)) >>> FB);
      endfunction

      function longint grad3(longint hh, longint x, longint y, longint z);
         int h;
         longint u, v;
         h = int'(hh & 15);
         u = (h < 8) ? x : y;
         v = (h < 4) ? y : ((h == 12 || h == 14) ? x : z);
         return (h[0] ? -u : u) + (h[1] ? -v : v);
      endfunction

      function longint grad2(longint hh, longint x, longint z);
         int h;
         longint u, v;
         h = int'(hh & 15);
         u = h[3] ? 0 : x;
         v = (h < 4) ? 0 : ((h == 12 || h == 14) ? x : z);
         return (h[0] ? -u : u) + (h[1] ? -v : v);
      endfunction

      // note an accepted request transfer
      function void note(noise_req_type r);
         longint sx, sy, sz, lx, ly, lz, fx, fy, fz, tx, ty, tz, n, total;
         longint b0, b1, c0, c1, h00, h01, h10, h11, gx, gy, gz, x0, x1;
         if (r.cmd == pnpe_pkg::CMD_LOAD) begin
            perm_tbl[r.tidx] = r.tval;
            return;
         end
         if (r.cmd == CMD_UNUSED) return;
         sx = longint'(r.px) + off_x;
         sz = longint'(r.pz) + off_z;
         lx = sx >>> FB;
         lz = sz >>> FB;
         fx = sx & (ONE - 1);
         fz = sz & (ONE - 1);
         tx = fade(fx);
         tz = fade(fz);
         if (r.cmd == pnpe_pkg::CMD_EVAL2D) begin
            b0 = pv(pv(lx)) + (lz & 255);
            b1 = pv(pv(lx + 1)) + (lz & 255);
            x0 = lerp(tx, grad2(pv(b0), fx, fz), grad3(pv(b1), fx - ONE, 0, fz));
            x1 = lerp(tx, grad3(pv(b0 + 1), fx, 0, fz - ONE),
                      grad3(pv(b1 + 1), fx - ONE, 0, fz - ONE));
            n = lerp(tz, x0, x1);
         end else begin
            sy = longint'(r.py) + off_y;
            ly = sy >>> FB;
            fy = sy & (ONE - 1);
            ty = fade(fy);
            // y-cell blends are only rebuilt on a new cell or column start
            if (r.col || ly != cell_y) begin
               c0 = pv(lx) + (ly & 255);
               c1 = pv(lx + 1) + (ly & 255);
               h00 = pv(c0) + (lz & 255);
               h01 = pv(c0 + 1) + (lz & 255);
               h10 = pv(c1) + (lz & 255);
               h11 = pv(c1 + 1) + (lz & 255);
               gx = fx - ONE; gy = fy - ONE; gz = fz - ONE;
               cell_y = ly;
               blend[0] = lerp(tx, grad3(pv(h00), fx, fy, fz), grad3(pv(h10), gx, fy, fz));
               blend[1] = lerp(tx, grad3(pv(h01), fx, gy, fz), grad3(pv(h11), gx, gy, fz));
               blend[2] = lerp(tx, grad3(pv(h00 + 1), fx, fy, gz),
                               grad3(pv(h10 + 1), gx, fy, gz));
               blend[3] = lerp(tx, grad3(pv(h01 + 1), fx, gy, gz),
                               grad3(pv(h11 + 1), gx, gy, gz));
            end
            n = lerp(tz, lerp(ty, blend[0], blend[1]), lerp(ty, blend[2], blend[3]));
         end
         total = longint'(r.acc) + n * (longint'(1) << shift);
         if (total > longint'(pnpe_pkg::ACC_MAX)) total = pnpe_pkg::ACC_MAX;
         if (total < longint'(pnpe_pkg::ACC_MIN)) total = pnpe_pkg::ACC_MIN;
         pending.push_back(total[pnpe_pkg::ACC_W-1:0]);
      endfunction

      function void check(logic signed [pnpe_pkg::ACC_W-1:0] got);
         logic signed [pnpe_pkg::ACC_W-1:0] want;
         if (pending.size() == 0) begin
            $error("unexpected acc_out transfer: actual %0d", got);
            errors++;
            return;
         end
         want = pending.pop_front();
         if (got !== want) begin
            $error("acc_out mismatch: expected %0d actual %0d", want, got);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write = 1'b0;
   logic [pnpe_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [pnpe_pkg::OFF_W-1:0] csr_data = '0;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [pnpe_pkg::CMD_W-1:0] req_cmd = pnpe_pkg::CMD_LOAD;
   logic [pnpe_pkg::TBL_AW-1:0] req_table_index = '0;
   logic [pnpe_pkg::TBL_DW-1:0] req_table_value = '0;
   logic signed [pnpe_pkg::POS_W-1:0] req_pos_x = '0, req_pos_y = '0, req_pos_z = '0;
   logic req_column_start = 1'b0;
   logic signed [pnpe_pkg::ACC_W-1:0] req_acc_in = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [pnpe_pkg::ACC_W-1:0] rsp_acc_out;

   scoreboard_type sb = new();
   bit quiet = 1'b0;
   bit hold_req = 1'b0;
   int cycles = 0;
   int stall_left = 0;
   int hold_left = 0;

   // column walk state
   noise_req_type col_item;
   int col_left = 0;

   perlin_noise_point_eval_unit dut (.*);

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // receiver: random stall bursts and one long hold-off
   always @(negedge clock) begin
      if (hold_req && hold_left == 0) begin
         hold_left = HOLD_OFF;
         hold_req = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (quiet) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if ($urandom_range(0, 4) == 0) begin
         stall_left = $urandom_range(0, 3);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock)
      if (!reset && rsp_valid && !rsp_stall) sb.check(rsp_acc_out);

   task automatic send(noise_req_type r);
      int gap;
      req_cmd <= r.cmd; req_table_index <= r.tidx; req_table_value <= r.tval;
      req_pos_x <= r.px; req_pos_y <= r.py; req_pos_z <= r.pz;
      req_column_start <= r.col; req_acc_in <= r.acc;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      sb.note(r);
      @(negedge clock);
      if (!quiet && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 4);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic csr_wr(logic [pnpe_pkg::CSR_IDX_W-1:0] idx,
                         logic [pnpe_pkg::OFF_W-1:0] val);
      req_valid <= 1'b0;
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (DRAIN) @(negedge clock);
      csr_write <= 1'b1; csr_index <= idx; csr_data <= val;
      @(negedge clock);
      csr_write <= 1'b0;
      sb.set_reg(idx, val);
   endtask

   function automatic noise_req_type blank(logic [pnpe_pkg::CMD_W-1:0] c);
      noise_req_type r;
      r.cmd = c;
      r.tidx = pnpe_pkg::TBL_AW'($urandom);
      r.tval = pnpe_pkg::TBL_DW'($urandom);
      r.px = 0; r.py = 0; r.pz = 0; r.col = 0; r.acc = 0;
      return r;
   endfunction

   function automatic logic signed [pnpe_pkg::POS_W-1:0] rand_pos();
      if ($urandom_range(0, 9) == 0) return pnpe_pkg::POS_W'({$urandom, $urandom});
      return $signed($urandom_range(0, 32'h3FF_FFFF)) - 40'sh200_0000;
   endfunction

   function automatic logic signed [pnpe_pkg::ACC_W-1:0] rand_acc();
      case ($urandom_range(0, 5))
         0: return pnpe_pkg::ACC_MAX - $urandom_range(0, 32'hFFFFF);
         1: return pnpe_pkg::ACC_MIN + $urandom_range(0, 32'hFFFFF);
         2, 3: return pnpe_pkg::ACC_W'({$urandom, $urandom});
         default: return $signed({16'h0, $urandom}) - 48'sh8000_0000;
      endcase
   endfunction

   function automatic noise_req_type next_item();
      noise_req_type r;
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 8) return blank(pnpe_pkg::CMD_LOAD);
      if (pick < 11) begin
         r = blank(CMD_UNUSED);
         r.px = rand_pos(); r.acc = rand_acc();
         return r;
      end
      if (pick < 33) begin
         r = blank(pnpe_pkg::CMD_EVAL2D);
         r.px = rand_pos(); r.py = rand_pos(); r.pz = rand_pos();
         r.col = 1'($urandom); r.acc = rand_acc();
         return r;
      end
      // 3D column walk: mostly same y cell, start flag usually on the first point
      if (col_left == 0) begin
         col_left = $urandom_range(3, 10);
         col_item = blank(pnpe_pkg::CMD_EVAL3D);
         col_item.px = rand_pos(); col_item.py = rand_pos(); col_item.pz = rand_pos();
         col_item.col = ($urandom_range(0, 9) != 0);
      end else begin
         col_item.py = col_item.py + $urandom_range(0, 16'h6000);
         col_item.col = ($urandom_range(0, 19) == 0);
         if ($urandom_range(0, 3) == 0) col_item.pz = col_item.pz + $urandom_range(0, 16'hFFFF);
      end
      col_left--;
      col_item.acc = rand_acc();
      return col_item;
   endfunction

   initial begin
      noise_req_type r;
      byte unsigned perm [256];
      int j;

      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // whole table first, so no evaluate reads an unwritten entry
      foreach (perm[i]) perm[i] = 8'(i);
      for (int i = 255; i > 0; i--) begin
         j = $urandom_range(0, i);
         {perm[i], perm[j]} = {perm[j], perm[i]};
      end
      for (int i = 0; i < 256; i++) begin
         r = blank(pnpe_pkg::CMD_LOAD);
         r.tidx = pnpe_pkg::TBL_AW'(i); r.tval = perm[i];
         send(r);
      end

      // directed: extremes, both modes, cache paths, unused cmd, saturation
      for (int k = 0; k < 20; k++) begin
         r = blank((k % 2) ? pnpe_pkg::CMD_EVAL3D : pnpe_pkg::CMD_EVAL2D);
         case (k / 2)
            0: ;
            1: begin r.px = 40'sh7F_FFFF_FFFF; r.py = 40'sh7F_FFFF_FFFF; r.pz = 40'sh7F_FFFF_FFFF; end
            2: begin r.px = 40'sh80_0000_0000; r.py = 40'sh80_0000_0000; r.pz = 40'sh80_0000_0000; end
            3: begin r.px = 40'sh1_8000; r.py = 40'sh2_4000; r.pz = 40'sh3_C000; r.col = 1; end
            4: begin r.px = 40'sh1_8000; r.py = 40'sh2_F000; r.pz = 40'sh3_C000; end
            5: begin r.px = -40'sh1; r.py = -40'sh1; r.pz = -40'sh1; r.acc = pnpe_pkg::ACC_MAX; end
            6: begin r.px = 40'sh7FFF; r.py = 40'sh7FFF; r.pz = 40'shFFFF; r.acc = pnpe_pkg::ACC_MIN; end
            7: begin r.px = 40'sh5_1234; r.py = 40'sh2_8000; r.pz = 40'sh9_9999; r.col = 1; end
            8: begin r = blank(CMD_UNUSED); r.px = 40'sh5; end
            default: begin r.px = rand_pos(); r.py = rand_pos(); r.pz = rand_pos();
                     r.acc = rand_acc(); end
         endcase
         send(r);
      end

      for (int ph = 0; ph < 6; ph++) begin
         csr_wr(pnpe_pkg::CSR_OFFSET_X, OX[ph]);
         csr_wr(pnpe_pkg::CSR_OFFSET_Y, OY[ph]);
         csr_wr(pnpe_pkg::CSR_OFFSET_Z, OZ[ph]);
         csr_wr(pnpe_pkg::CSR_AMP_SHIFT, AM[ph]);
         if (ph == 1) hold_req = 1'b1;
         if (ph == 5) quiet = 1'b1;
         // saturation edges with the current shift
         r = blank(pnpe_pkg::CMD_EVAL3D); r.px = 40'sh4000; r.py = 40'sh8000; r.pz = 40'shC000;
         r.col = 1; r.acc = pnpe_pkg::ACC_MAX;
         send(r);
         r.acc = pnpe_pkg::ACC_MIN;
         send(r);
         for (int n = 0; n < 270; n++) send(next_item());
      end
      req_valid <= 1'b0;

      while (sb.pending.size() != 0) @(negedge clock);
      repeat (DRAIN) @(negedge clock);
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

FILE: perlin_noise_point_eval_unit.f
hdl/pnpe_pkg.sv
hdl/pnpe_ram.sv
hdl/perlin_noise_point_eval_unit.sv
tb/tb.sv
